@@ rtl/core/buffer_pool_free_list_assert.svh @@
// Assertion macros shared by the buffer pool free list RTL.
// Each macro expects clk_i in the enclosing scope; BPFL_ASSERT also expects rst_ni.
`ifndef BUFFER_POOL_FREE_LIST_ASSERT_SVH
`define BUFFER_POOL_FREE_LIST_ASSERT_SVH

// Checked at every rising edge once reset is released
`define BPFL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge, reset included
`define BPFL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/core/bpfl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bpfl_pkg;

  // Field widths
  localparam int OFFSET_W   = 26;
  localparam int SIZE_W     = 17;
  localparam int COUNT_W    = 11;
  localparam int INDEX_W    = 10;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 17;
  localparam int DIV_CNT_W  = $clog2(OFFSET_W + 1);

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_SIZE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = CFG_IDX_W'(1);

  // Register reset values
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(4096);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);

  // Request opcodes
  localparam logic OP_GET  = 1'b0;
  localparam logic OP_FREE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET_RD,
    S_GET_MUL,
    S_DIV,
    S_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;
    logic div_start;
    logic rd_issue;
    logic get_empty;
    logic get_commit;
    logic free_commit;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic in_op;
    logic fill_zero;
    logic div_busy;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/bpfl_intf.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Request channel: get or free
interface bpfl_req_if import bpfl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                op;
  logic [OFFSET_W-1:0] offset;

  modport source (output valid, output op, output offset, input ready);
  modport sink   (input valid, input op, input offset, output ready);
endinterface

// Response channel: one result per request
interface bpfl_rsp_if import bpfl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  buffer_index;
  logic [OFFSET_W-1:0] buffer_offset;
  logic [COUNT_W-1:0]  free_count;

  modport source (output valid, output status, output buffer_index,
                  output buffer_offset, output free_count, input ready);
  modport sink   (input valid, input status, input buffer_index,
                  input buffer_offset, input free_count, output ready);
endinterface

// Register write channel
interface bpfl_cfg_if import bpfl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bpfl_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle
module bpfl_div import bpfl_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [OFFSET_W-1:0] dividend_i,
  input  wire logic [SIZE_W-1:0]   divisor_i,
  output logic                     busy_o,
  output logic [OFFSET_W-1:0]      quotient_o
);

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [SIZE_W-1:0]    rem_q, rem_d;
  logic [OFFSET_W-1:0]  quo_q, quo_d;
  logic [SIZE_W-1:0]    dvs_q, dvs_d;
  logic [SIZE_W:0]      rem_sh;
  logic [SIZE_W:0]      diff;

  // Trial subtract
  always_comb begin
    rem_sh = {rem_q, quo_q[OFFSET_W-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(OFFSET_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[SIZE_W]) begin
        rem_d = diff[SIZE_W-1:0];
        quo_d = {quo_q[OFFSET_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[SIZE_W-1:0];
        quo_d = {quo_q[OFFSET_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ rtl/core/bpfl_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Datapath: registers, free queue memory, divider, multiplier, output register
module bpfl_dp import bpfl_pkg::*; #(
  parameter int POOL_DEPTH = 1024
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  bpfl_req_if.sink       req_i,
  bpfl_rsp_if.source     rsp_o,
  bpfl_cfg_if.sink       cfg_i,
  input  wire ctrl_cmd_t cmd_i,
  output ctrl_sts_t      sts_o
);

  localparam int PW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int FW = $clog2(POOL_DEPTH + 1);
  localparam int WW = (FW > COUNT_W) ? FW : COUNT_W;
  localparam logic [WW-1:0] DEPTH_W  = WW'(POOL_DEPTH);
  localparam logic [FW-1:0] DEPTH_F  = FW'(POOL_DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(POOL_DEPTH - 1);
  localparam int RST_N    = (int'(COUNT_RESET) > POOL_DEPTH) ? POOL_DEPTH : int'(COUNT_RESET);
  localparam int RST_TAIL = (RST_N == POOL_DEPTH) ? 0 : RST_N;

  // Control registers
  logic [SIZE_W-1:0] size_q;
  logic [FW-1:0]     eff_n_q;
  logic [PW-1:0]     head_q, tail_q, tail0_q;
  logic [FW-1:0]     fill_q, pushes_q;
  logic              out_valid_q;

  // Payload registers
  logic [INDEX_W-1:0]  mem [POOL_DEPTH];
  logic [INDEX_W-1:0]  rd_data_q;
  logic                rd_written_q;
  status_e             res_status_q;
  logic [INDEX_W-1:0]  res_idx_q;
  logic [OFFSET_W-1:0] res_boff_q;
  status_e             out_status_q;
  logic [INDEX_W-1:0]  out_idx_q;
  logic [OFFSET_W-1:0] out_boff_q;
  logic [COUNT_W-1:0]  out_fill_q;

  logic                cfg_xfer, req_xfer, rsp_xfer;
  logic [SIZE_W-1:0]   eff_size;
  logic [WW-1:0]       cfg_cnt_w;
  logic [FW-1:0]       new_n;
  logic [PW-1:0]       new_tail;
  logic [FW-1:0]       rel;
  logic [INDEX_W-1:0]  get_idx;
  logic [OFFSET_W+0:0] prod;
  logic                div_busy;
  logic [OFFSET_W-1:0] quot;
  logic                reject;
  logic                push;

  assign cfg_i.ready = 1'b1;
  assign cfg_xfer    = cfg_i.valid && cfg_i.ready;
  assign req_i.ready = cmd_i.in_ready;
  assign req_xfer    = req_i.valid && req_i.ready;
  assign rsp_xfer    = rsp_o.valid && rsp_o.ready;

  // Effective size and refill values from a count write
  always_comb begin
    eff_size  = (size_q == '0) ? SIZE_W'(1) : size_q;
    cfg_cnt_w = WW'(cfg_i.data[COUNT_W-1:0]);
    new_n     = (cfg_cnt_w > DEPTH_W) ? DEPTH_F : FW'(cfg_cnt_w);
    new_tail  = (new_n == DEPTH_F) ? '0 : PW'(new_n);
  end

  // Distance of the head from the first slot written since refill
  always_comb begin
    if (head_q >= tail0_q) begin
      rel = FW'(head_q - tail0_q);
    end else begin
      rel = FW'(head_q) + DEPTH_F - FW'(tail0_q);
    end
  end

  // Popped index and its byte offset
  assign get_idx = rd_written_q ? rd_data_q : INDEX_W'(head_q);
  assign prod    = {17'b0, get_idx} * {10'b0, eff_size};

  // Free decision
  assign reject = (quot >= OFFSET_W'(eff_n_q)) || (fill_q == DEPTH_F);
  assign push   = cmd_i.free_commit && !reject;

  bpfl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start && req_xfer),
    .dividend_i (req_i.offset),
    .divisor_i  (eff_size),
    .busy_o     (div_busy),
    .quotient_o (quot)
  );

  // Queue pointers, fill and config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= SIZE_RESET;
      eff_n_q  <= FW'(RST_N);
      head_q   <= '0;
      tail_q   <= PW'(RST_TAIL);
      tail0_q  <= PW'(RST_TAIL);
      fill_q   <= FW'(RST_N);
      pushes_q <= '0;
    end else if (cfg_xfer) begin
      if (cfg_i.index == REG_SIZE) begin
        size_q <= cfg_i.data[SIZE_W-1:0];
      end else if (cfg_i.index == REG_COUNT) begin
        eff_n_q  <= new_n;
        head_q   <= '0;
        tail_q   <= new_tail;
        tail0_q  <= new_tail;
        fill_q   <= new_n;
        pushes_q <= '0;
      end
    end else if (cmd_i.get_commit) begin
      head_q <= (head_q == LAST_PTR) ? '0 : head_q + 1'b1;
      fill_q <= fill_q - 1'b1;
    end else if (push) begin
      tail_q <= (tail_q == LAST_PTR) ? '0 : tail_q + 1'b1;
      fill_q <= fill_q + 1'b1;
      if (pushes_q != DEPTH_F) begin
        pushes_q <= pushes_q + 1'b1;
      end
    end
  end

  // Free queue memory: write at tail, registered read at head
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[tail_q] <= quot[INDEX_W-1:0];
    end
    if (cmd_i.rd_issue) begin
      rd_data_q    <= mem[head_q];
      rd_written_q <= rel < pushes_q;
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.get_empty) begin
      res_status_q <= ST_EMPTY;
      res_idx_q    <= '0;
      res_boff_q   <= '0;
    end else if (cmd_i.get_commit) begin
      res_status_q <= ST_OK;
      res_idx_q    <= get_idx;
      res_boff_q   <= prod[OFFSET_W-1:0];
    end else if (cmd_i.free_commit) begin
      res_status_q <= reject ? ST_REJECT : ST_OK;
      res_idx_q    <= quot[INDEX_W-1:0];
      res_boff_q   <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_idx_q    <= res_idx_q;
      out_boff_q   <= res_boff_q;
      out_fill_q   <= COUNT_W'(fill_q);
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.buffer_index  = out_idx_q;
  assign rsp_o.buffer_offset = out_boff_q;
  assign rsp_o.free_count    = out_fill_q;

  // Status to controller
  assign sts_o.in_valid  = req_i.valid;
  assign sts_o.in_op     = req_i.op;
  assign sts_o.fill_zero = (fill_q == '0);
  assign sts_o.div_busy  = div_busy;
  assign sts_o.out_free  = !out_valid_q || rsp_o.ready;

  `include "buffer_pool_free_list_assert.svh"

  `BPFL_ASSERT(a_fill_max, fill_q <= DEPTH_F, "free queue fill above depth")
  `BPFL_ASSERT(a_pop_nonempty, cmd_i.get_commit |-> fill_q != '0, "pop from empty queue")
  `BPFL_ASSERT(a_push_fill, push |=> fill_q == FW'($past(fill_q) + 1'b1), "push lost")
  `BPFL_ASSERT(a_load_div_idle, cmd_i.out_load |-> !div_busy, "result before quotient")

endmodule

`default_nettype wire

@@ rtl/core/bpfl_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Sequencer for get and free requests
module bpfl_ctrl import bpfl_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ctrl_sts_t sts_i,
  output ctrl_cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          if (sts_i.in_op == OP_FREE) begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end else begin
            state_d = S_GET_RD;
          end
        end
      end
      S_GET_RD: begin
        if (sts_i.fill_zero) begin
          cmd_o.get_empty = 1'b1;
          state_d         = S_DONE;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d        = S_GET_MUL;
        end
      end
      S_GET_MUL: begin
        cmd_o.get_commit = 1'b1;
        state_d          = S_DONE;
      end
      S_DIV: begin
        if (!sts_i.div_busy) begin
          cmd_o.free_commit = 1'b1;
          state_d           = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/buffer_pool_free_list.sv @@
// Buffer pool free list: hands out and takes back equal-sized buffers.
// req_i carries op (get or free) and, for a free, the buffer's byte offset.
// rsp_o returns one result per request: status, index, byte offset of a
// handed-out buffer and the number of free buffers left.
// cfg_i writes buffer_size (index 0) or buffer_count (index 1); a count
// write refills the queue with indices 0 to count-1, count clamped to
// POOL_DEPTH. Write registers only while no request is in flight.
// Requests are handled one at a time. A get passes a queue memory read,
// an index-times-size multiply and an output load before its result is
// valid; when the pool is empty the read and multiply are skipped. A free
// waits on the bit-serial divider that turns the offset into an index (26
// quotient bits, one per cycle), then its result is registered and loaded.
// A new request is taken as soon as the previous result sits in the output
// register; if the receiver stalls, that result is held and the next
// request waits one step short of its output.
// After reset: size 4096, count clamped to POOL_DEPTH, all buffers free,
// no result pending. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module buffer_pool_free_list import bpfl_pkg::*; #(
  parameter int POOL_DEPTH = 1024
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bpfl_req_if.sink   req_i,
  bpfl_rsp_if.source rsp_o,
  bpfl_cfg_if.sink   cfg_i
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  bpfl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  bpfl_dp #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

`default_nettype wire
